[sv/cmqs_pkg.sv]
package cmqs_pkg;

  // operand width the magnitude stage squares; larger deltas are pre-scaled down to it
  localparam int unsigned NORM_W = 62;

  // pipeline advance and the valid bit entering a square-root chain
  typedef struct packed {
    logic adv;
    logic valid;
  } cmqs_ctl_t;

endpackage

[sv/cmqs_mul.sv]
module cmqs_mul #(
  parameter int unsigned W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [2*W-1:0]   p
);
  import cmqs_pkg::*;

  localparam int unsigned L = W / 2;
  localparam int unsigned H = W - L;

  logic [2*H-1:0] hh_r;
  logic [H+L-1:0] hl_r;
  logic [H+L-1:0] lh_r;
  logic [2*L-1:0] ll_r;
  logic [2*W-1:0] p_r;
  logic [2*W-1:0] p_nxt;

  // split into half-width partial products, registered, then summed into the product register
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= a[W-1:L] * b[W-1:L];
      hl_r <= a[W-1:L] * b[L-1:0];
      lh_r <= a[L-1:0] * b[W-1:L];
      ll_r <= a[L-1:0] * b[L-1:0];
      p_r  <= p_nxt;
    end
  end

  always_comb begin
    p_nxt = ((2*W)'(hh_r) << (2*L)) + (((2*W)'(hl_r) + (2*W)'(lh_r)) << L) + (2*W)'(ll_r);
  end

  assign p = p_r;

endmodule

[sv/cmqs_isqrt.sv]
module cmqs_isqrt #(
  parameter int unsigned IW = 126,
  parameter int unsigned PW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmqs_pkg::cmqs_ctl_t       ctl,
  input  logic [IW-1:0]             x,
  input  logic [PW-1:0]             pay_in,
  output logic                      valid_out,
  output logic [IW/2-1:0]           root,
  output logic [PW-1:0]             pay_out
);
  import cmqs_pkg::*;

  localparam int unsigned RW  = IW / 2;
  localparam int unsigned RMW = RW + 3;

  // element 0 is the chain input, element i+1 the register of step i
  logic           v_q    [RW+1];
  logic [RMW-1:0] rem_q  [RW+1];
  logic [RW-1:0]  root_q [RW+1];
  logic [IW-1:0]  xs_q   [RW+1];
  logic [PW-1:0]  pay_q  [RW+1];

  assign v_q[0]    = ctl.valid;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign xs_q[0]   = x;
  assign pay_q[0]  = pay_in;

  // restoring digit recurrence, one result bit per step
  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RMW-1:0] remsh;
    logic [RMW-1:0] trial;
    logic           take;
    logic [RMW-1:0] rem_nxt;
    logic [RW-1:0]  root_nxt;

    always_comb begin
      remsh    = {rem_q[i][RW:0], xs_q[i][IW-1:IW-2]};
      trial    = RMW'({root_q[i], 2'b01});
      take     = (remsh >= trial);
      rem_nxt  = take ? remsh - trial : remsh;
      root_nxt = {root_q[i][RW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_q[i+1] <= 1'b0;
      end else if (ctl.adv) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_q[i+1]  <= rem_nxt;
        root_q[i+1] <= root_nxt;
        xs_q[i+1]   <= xs_q[i] << 2;
        pay_q[i+1]  <= pay_q[i];
      end
    end
  end

  assign valid_out = v_q[RW];
  assign root      = root_q[RW];
  assign pay_out   = pay_q[RW];

endmodule

[sv/complex_monic_quadratic_solver_top.sv]
// Solves z^2 + b z + c = 0 for complex Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS coefficients.
// in_tdata carries b_real, b_imag, c_real, c_imag; out_tdata carries root1_real, root1_imag,
// root2_real, root2_imag (root1 = (-b - sqrt(delta))/2), out_tuser the overflow flag that is
// set when any component saturated. A fully pipelined datapath takes one request every
// cycle while the output is not stalled. The two bit-serial square-root chains take 63
// steps for |delta| and RW steps for the root components, with RW half the (even-rounded)
// radicand width of the second chain. A stall at the output freezes the whole pipeline.
module complex_monic_quadratic_solver_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // b_real, b_imag, c_real, c_imag
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // root1_real, root1_imag, root2_real, root2_imag
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     out_tdata,
  // overflow
  output logic                                  out_tuser
);
  import cmqs_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned BW   = ((4*DW+7)/8)*8;
  localparam int unsigned XW   = ((2*DW > DW+F+2) ? 2*DW : DW+F+2) + 2;
  localparam int unsigned EW   = (XW > NORM_W) ? XW : NORM_W;
  localparam int unsigned KW   = $clog2(XW+1);
  localparam int unsigned SQW  = 2*NORM_W + 2;
  localparam int unsigned MW   = XW + 1;
  localparam int unsigned SW0  = MW + F;
  localparam int unsigned SW   = SW0 + (SW0 % 2);
  localparam int unsigned RW   = SW / 2;
  localparam int unsigned TW   = ((DW > RW) ? DW : RW) + 3;
  localparam int unsigned MPW  = KW + 1 + XW + 2*DW;

  logic en;

  // ---- stage 0: capture
  logic                 v0_r;
  logic signed [DW-1:0] br0_r, bi0_r, cr0_r, ci0_r;
  logic [DW-1:0]        mbr, mbi;

  // ---- stages 1-2: b products
  logic                 v1_r, v2_r;
  logic signed [DW-1:0] br1_r, bi1_r, cr1_r, ci1_r, br2_r, bi2_r, cr2_r, ci2_r;
  logic                 ng1_r, ng2_r;
  logic [2*DW-1:0]      pa, pb, pc;

  // ---- stage 3: delta
  logic                 v3_r;
  logic signed [XW-1:0] dr3_r, di3_r, drf, dif, dip;
  logic signed [DW-1:0] br3_r, bi3_r;

  // ---- stage 4: magnitudes and pre-scale
  logic                 v4_r;
  logic [XW-1:0]        ar, ai, ar4_r, ai4_r, orv;
  logic [KW-1:0]        bl, k4, k4_r;
  logic signed [XW-1:0] dr4_r;
  logic                 dn4_r;
  logic signed [DW-1:0] br4_r, bi4_r;

  // ---- stage 5: scaled operands
  logic                 v5_r;
  logic [EW-1:0]        arx, aix;
  logic [NORM_W-1:0]    an5_r, bn5_r;
  logic [KW-1:0]        k5_r, k6_r, k7_r;
  logic signed [XW-1:0] dr5_r, dr6_r, dr7_r;
  logic                 dn5_r, dn6_r, dn7_r;
  logic signed [DW-1:0] br5_r, bi5_r, br6_r, bi6_r, br7_r, bi7_r;
  logic                 v6_r, v7_r;
  logic [2*NORM_W-1:0]  sqa, sqb;

  // ---- stage 8: sum of squares
  logic                 v8_r;
  logic [SQW-1:0]       sum8_r;
  logic [MPW-1:0]       mpay8_r;

  // ---- magnitude root
  logic                 mv;
  logic [SQW/2-1:0]     mroot;
  logic [MPW-1:0]       mpay;
  logic [KW-1:0]        mk;
  logic                 mdn;
  logic signed [XW-1:0] mdr;
  logic signed [DW-1:0] mbr9, mbi9;

  // ---- stage 9: radicands
  logic                   v9_r;
  logic [MW-1:0]          mag;
  logic signed [MW+1:0]   sre, sim;
  logic [MW:0]            cre, cim;
  logic [SW-1:0]          rre9_r, rim9_r;
  logic signed [DW-1:0]   br9_r, bi9_r;
  logic                   dn9_r;

  // ---- component roots
  logic                   rv, rv_b;
  logic [RW-1:0]          rr, ri;
  logic [2*DW-1:0]        rpay;
  logic                   rdn;

  // ---- output
  logic                   out_valid_r, out_valid_nxt;
  logic [4*DW-1:0]        out_data_r, out_data_nxt;
  logic                   ovf_r, ovf_nxt;
  logic signed [TW-1:0]   rrs, ris, bre, bie, z1r, z1i, z2r, z2i;
  logic [DW:0]            s1r, s1i, s2r, s2i;

  function automatic logic [DW:0] sat(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] hi;
    logic signed [TW-1:0] lo;
    hi = TW'($signed({1'b0, {(DW-1){1'b1}}}));
    lo = -hi - TW'(1);
    if (v > hi) begin
      sat = {1'b1, hi[DW-1:0]};
    end else if (v < lo) begin
      sat = {1'b1, lo[DW-1:0]};
    end else begin
      sat = {1'b0, v[DW-1:0]};
    end
  endfunction

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- stage 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br0_r <= in_tdata[DW-1:0];
      bi0_r <= in_tdata[2*DW-1:DW];
      cr0_r <= in_tdata[3*DW-1:2*DW];
      ci0_r <= in_tdata[4*DW-1:3*DW];
    end
  end

  assign mbr = br0_r[DW-1] ? DW'(-br0_r) : DW'(br0_r);
  assign mbi = bi0_r[DW-1] ? DW'(-bi0_r) : DW'(bi0_r);

  cmqs_mul #(.W(DW)) u_mul_rr (.clk(clk), .en(en), .a(mbr), .b(mbr), .p(pa));
  cmqs_mul #(.W(DW)) u_mul_ii (.clk(clk), .en(en), .a(mbi), .b(mbi), .p(pb));
  cmqs_mul #(.W(DW)) u_mul_ri (.clk(clk), .en(en), .a(mbr), .b(mbi), .p(pc));

  // ---------------- stages 1-2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br1_r <= br0_r;  bi1_r <= bi0_r;  cr1_r <= cr0_r;  ci1_r <= ci0_r;
      ng1_r <= br0_r[DW-1] ^ bi0_r[DW-1];
      br2_r <= br1_r;  bi2_r <= bi1_r;  cr2_r <= cr1_r;  ci2_r <= ci1_r;
      ng2_r <= ng1_r;
    end
  end

  // ---------------- stage 3: delta = b*b - 4c, back to FRAC_BITS
  always_comb begin
    dip = ng2_r ? -(XW'(pc) << 1) : (XW'(pc) << 1);
    drf = XW'(pa) - XW'(pb) - (XW'(cr2_r) <<< (F+2));
    dif = dip - (XW'(ci2_r) <<< (F+2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr3_r <= drf >>> F;
      di3_r <= dif >>> F;
      br3_r <= br2_r;
      bi3_r <= bi2_r;
    end
  end

  // ---------------- stage 4: absolute values and scale count
  always_comb begin
    ar  = dr3_r[XW-1] ? XW'(-dr3_r) : XW'(dr3_r);
    ai  = di3_r[XW-1] ? XW'(-di3_r) : XW'(di3_r);
    orv = ar | ai;
    bl  = '0;
    for (int i = 0; i < XW; i++) begin
      if (orv[i]) begin
        bl = KW'(i + 1);
      end
    end
    k4 = (bl > KW'(NORM_W)) ? bl - KW'(NORM_W) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar4_r <= ar;
      ai4_r <= ai;
      k4_r  <= k4;
      dr4_r <= dr3_r;
      dn4_r <= di3_r[XW-1];
      br4_r <= br3_r;
      bi4_r <= bi3_r;
    end
  end

  // ---------------- stage 5: scale both parts together
  assign arx = EW'(ar4_r) >> k4_r;
  assign aix = EW'(ai4_r) >> k4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an5_r <= arx[NORM_W-1:0];
      bn5_r <= aix[NORM_W-1:0];
      k5_r  <= k4_r;   dr5_r <= dr4_r;  dn5_r <= dn4_r;  br5_r <= br4_r;  bi5_r <= bi4_r;
      k6_r  <= k5_r;   dr6_r <= dr5_r;  dn6_r <= dn5_r;  br6_r <= br5_r;  bi6_r <= bi5_r;
      k7_r  <= k6_r;   dr7_r <= dr6_r;  dn7_r <= dn6_r;  br7_r <= br6_r;  bi7_r <= bi6_r;
    end
  end

  cmqs_mul #(.W(NORM_W)) u_mul_sqr (.clk(clk), .en(en), .a(an5_r), .b(an5_r), .p(sqa));
  cmqs_mul #(.W(NORM_W)) u_mul_sqi (.clk(clk), .en(en), .a(bn5_r), .b(bn5_r), .p(sqb));

  // ---------------- stage 8
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum8_r  <= SQW'(sqa) + SQW'(sqb);
      mpay8_r <= {k7_r, dn7_r, dr7_r, bi7_r, br7_r};
    end
  end

  cmqs_isqrt #(.IW(SQW), .PW(MPW)) u_sqrt_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cmqs_ctl_t'{adv: en, valid: v8_r}),
    .x         (sum8_r),
    .pay_in    (mpay8_r),
    .valid_out (mv),
    .root      (mroot),
    .pay_out   (mpay)
  );

  assign {mk, mdn, mdr, mbi9, mbr9} = mpay;

  // ---------------- stage 9: (|delta| +- re)/2, scaled for the root
  always_comb begin
    mag = MW'(mroot) << mk;
    sre = $signed({2'b00, mag}) + (MW+2)'(mdr);
    sim = $signed({2'b00, mag}) - (MW+2)'(mdr);
    cre = sre[MW+1] ? '0 : sre[MW:0];
    cim = sim[MW+1] ? '0 : sim[MW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rre9_r <= SW'(cre) << (F-1);
      rim9_r <= SW'(cim) << (F-1);
      br9_r  <= mbr9;
      bi9_r  <= mbi9;
      dn9_r  <= mdn;
    end
  end

  cmqs_isqrt #(.IW(SW), .PW(2*DW)) u_sqrt_re (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cmqs_ctl_t'{adv: en, valid: v9_r}),
    .x         (rre9_r),
    .pay_in    ({bi9_r, br9_r}),
    .valid_out (rv),
    .root      (rr),
    .pay_out   (rpay)
  );

  cmqs_isqrt #(.IW(SW), .PW(1)) u_sqrt_im (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cmqs_ctl_t'{adv: en, valid: v9_r}),
    .x         (rim9_r),
    .pay_in    (dn9_r),
    .valid_out (rv_b),
    .root      (ri),
    .pay_out   (rdn)
  );

  // ---------------- output: (-b -+ r) / 2 with floor, saturate
  always_comb begin
    rrs = TW'(rr);
    ris = rdn ? -TW'(ri) : TW'(ri);
    bre = TW'($signed(rpay[DW-1:0]));
    bie = TW'($signed(rpay[2*DW-1:DW]));
    z1r = (-bre - rrs) >>> 1;
    z1i = (-bie - ris) >>> 1;
    z2r = (-bre + rrs) >>> 1;
    z2i = (-bie + ris) >>> 1;
    s1r = sat(z1r);
    s1i = sat(z1i);
    s2r = sat(z2r);
    s2i = sat(z2i);
    out_data_nxt  = {s2i[DW-1:0], s2r[DW-1:0], s1i[DW-1:0], s1r[DW-1:0]};
    ovf_nxt       = s1r[DW] | s1i[DW] | s2r[DW] | s2i[DW];
    out_valid_nxt = en ? (rv & rv_b) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = BW'(out_data_r);
  assign out_tuser  = ovf_r;

endmodule

[sv/cmqs_checker.sv]
module cmqs_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0]     out_tdata,
  input logic                                  out_tuser
);
  import cmqs_pkg::*;

  // a result held back must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a stalled output freezes the whole pipeline
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while output stalled");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tdata))
    else $error("request offered with unknown data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind complex_monic_quadratic_solver_top cmqs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cmqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/sv/tb_complex_monic_quadratic_solver_top.sv]
module tb_complex_monic_quadratic_solver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned N_RANDOM = 1150;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 250;

  typedef struct {
    logic signed [DW-1:0] z1_re;
    logic signed [DW-1:0] z1_im;
    logic signed [DW-1:0] z2_re;
    logic signed [DW-1:0] z2_im;
    logic                 sat;
  } roots_t;

  typedef struct {
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    logic signed [DW-1:0] c_re;
    logic signed [DW-1:0] c_im;
    bit                   known;
    roots_t               ans;
  } coef_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [4*DW-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [4*DW-1:0]  out_tdata;
  logic             out_tuser;

  roots_t      pending_roots[$];
  coef_row_t   coef_table[$];
  int unsigned err_cnt = 0;
  int unsigned roots_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;

  complex_monic_quadratic_solver_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt_floor(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= x) r = cand;
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] clip(input logic signed [127:0] v, inout logic sat);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (DW-1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) begin
      sat = 1'b1;
      return hi_lim[DW-1:0];
    end
    if (v < lo_lim) begin
      sat = 1'b1;
      return lo_lim[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic roots_t solve_roots(input logic signed [DW-1:0] b_re_in,
                                         input logic signed [DW-1:0] b_im_in,
                                         input logic signed [DW-1:0] c_re_in,
                                         input logic signed [DW-1:0] c_im_in);
    logic signed [127:0] br, bi, cr, ci, dr, di, ar, ai, mag, s_re, s_im, rr, ri;
    logic [127:0] sum;
    int k;
    roots_t res;
    br = b_re_in; bi = b_im_in; cr = c_re_in; ci = c_im_in;
    dr = br * br - bi * bi - (cr <<< (FB + 2));
    di = ((br * bi) <<< 1) - (ci <<< (FB + 2));
    dr = dr >>> FB;
    di = di >>> FB;
    ar = (dr < 0) ? -dr : dr;
    ai = (di < 0) ? -di : di;
    k = 0;
    // scale huge deltas down so the squares fit, then scale the magnitude back
    while ((ar >>> 62) != 0 || (ai >>> 62) != 0) begin
      ar = ar >>> 1;
      ai = ai >>> 1;
      k++;
    end
    sum = ar * ar + ai * ai;
    mag = isqrt_floor(sum);
    mag = mag <<< k;
    s_re = mag + dr;
    s_im = mag - dr;
    if (s_re < 0) s_re = 0;
    if (s_im < 0) s_im = 0;
    rr = isqrt_floor(s_re << (FB - 1));
    ri = isqrt_floor(s_im << (FB - 1));
    if (di < 0) ri = -ri;
    res.sat = 1'b0;
    res.z1_re = clip((-br - rr) >>> 1, res.sat);
    res.z1_im = clip((-bi - ri) >>> 1, res.sat);
    res.z2_re = clip((-br + rr) >>> 1, res.sat);
    res.z2_im = clip((-bi + ri) >>> 1, res.sat);
    return res;
  endfunction

  function automatic logic signed [DW-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return {1'b0, {(DW-1){1'b1}}};
      3, 4: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      5: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
      6: return $signed($urandom_range(0, 64)) - 32;
      7: return '0;
      default: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
    endcase
  endfunction

  task automatic add_row(input logic [DW-1:0] br, bi, cr, ci,
                         input bit known = 1'b0, input roots_t ans = '{default: '0});
    coef_row_t row;
    row.b_re = br; row.b_im = bi; row.c_re = cr; row.c_im = ci;
    row.known = known; row.ans = ans;
    coef_table.push_back(row);
  endtask

  task automatic offer_coefs(input coef_row_t row);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {row.c_im, row.c_re, row.b_im, row.b_re};
    do @(posedge clk); while (!in_tready);
    if (row.known) pending_roots.push_back(row.ans);
    else pending_roots.push_back(solve_roots(row.b_re, row.b_im, row.c_re, row.c_im));
  endtask

  task automatic cmp_field(input string name, input logic [DW-1:0] want, got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  // result side: checks and back-pressure
  initial begin
    int unsigned hold_left;
    roots_t want;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        roots_seen++;
        if (pending_roots.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual %h", $realtime, out_tdata);
        end else begin
          want = pending_roots.pop_front();
          cmp_field("root1_real", want.z1_re, out_tdata[DW-1:0]);
          cmp_field("root1_imag", want.z1_im, out_tdata[2*DW-1:DW]);
          cmp_field("root2_real", want.z2_re, out_tdata[3*DW-1:2*DW]);
          cmp_field("root2_imag", want.z2_im, out_tdata[4*DW-1:3*DW]);
          if (want.sat !== out_tuser) begin
            err_cnt++;
            $display("%0t: overflow mismatch: expected %b, actual %b", $realtime,
                     want.sat, out_tuser);
          end
          if (out_tuser) sat_seen++;
        end
        // long hold-off so the pipeline fills and stalls its input
        if (roots_seen == 400) hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycle_cnt,
               pending_roots.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    coef_row_t row;
    roots_t zero_ans;
    roots_t unit_ans;
    zero_ans = '{default: '0};
    unit_ans = '{z1_re: 32'hFFFF0000, z1_im: '0, z2_re: 32'h00010000, z2_im: '0, sat: 1'b0};

    add_row('0, '0, '0, '0, 1'b1, zero_ans);
    add_row('0, '0, 32'hFFFF0000, '0, 1'b1, unit_ans);   // z^2 - 1
    add_row(32'h00020000, '0, '0, '0);
    add_row('0, '0, 32'h00010000, '0);                    // z^2 + 1, imaginary roots
    add_row('0, '0, '0, 32'h00010000);                    // Im delta negative
    add_row('0, '0, '0, 32'hFFFF0000);                    // Im delta positive
    add_row(32'h00010000, 32'h00010000, '0, '0);
    add_row(32'h00010000, 32'hFFFF0000, '0, '0);
    add_row(32'h80000000, '0, '0, '0);
    add_row(32'h7FFFFFFF, '0, '0, '0);
    add_row('0, 32'h80000000, '0, '0);
    add_row('0, 32'h7FFFFFFF, '0, '0);
    add_row('0, '0, 32'h80000000, '0);
    add_row('0, '0, 32'h7FFFFFFF, '0);
    add_row('0, '0, '0, 32'h80000000);
    add_row('0, '0, '0, 32'h7FFFFFFF);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_row(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_row(32'h00000001, '0, '0, '0);                    // floor of odd negative half
    add_row(32'h00040000, '0, 32'h00040000, '0);          // double root
    add_row(32'h00030000, 32'h00010000, 32'h00020000, 32'hFFFF0000);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (coef_table[i]) offer_coefs(coef_table[i]);

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 300) begin
        // sender pause until every request has come back
        in_tvalid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
      end
      row.b_re = rand_coef(); row.b_im = rand_coef();
      row.c_re = rand_coef(); row.c_im = rand_coef();
      row.known = 1'b0;
      offer_coefs(row);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d directed and %0d random coefficient sets, %0d results checked,",
             coef_table.size(), N_RANDOM, roots_seen);
    $display("%0d of them saturated, with stalls and a long output hold-off.", sat_seen);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[complex_monic_quadratic_solver_top.f]
sv/cmqs_pkg.sv
sv/cmqs_mul.sv
sv/cmqs_isqrt.sv
sv/complex_monic_quadratic_solver_top.sv
sv/cmqs_checker.sv
tb/sv/tb_complex_monic_quadratic_solver_top.sv
